@@ design/mrl_pkg.sv @@
// Package for the multichannel range low-pass filter.
// Types, command and status structs and fixed constants; no dependencies.
package mrl_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned CH_W      = 3;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned U_W       = 9;   // sample >> 3
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned INCH_W    = 19;
  localparam int unsigned CM_W      = 21;
  localparam int unsigned OPA_W     = 32;
  localparam int unsigned OPB_W     = 17;
  localparam int unsigned PROD_W    = OPA_W + OPB_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

  // 2.54 in Q.14
  localparam logic signed [OPB_W-1:0] CM_PER_INCH_Q14 = 17'sd41615;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_COEFF_A     = 3'd0,
    IDX_COEFF_B     = 3'd1,
    IDX_COEFF_C     = 3'd2,
    IDX_COEFF_D     = 3'd3,
    IDX_ACTIVE_MASK = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] a;
    logic signed [COEFF_W-1:0] b;
    logic signed [COEFF_W-1:0] c;
    logic signed [COEFF_W-1:0] d;
    logic        [MASK_W-1:0]  mask;
  } coeff_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CX,
    ST_DU,
    ST_AX,
    ST_BU,
    ST_CM,
    ST_DONE
  } ctrl_state_t;

  // Multiplier operand pair
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CX,
    MUL_DU,
    MUL_AX,
    MUL_BU,
    MUL_CM
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_SH
  } acc_op_t;

  typedef struct packed {
    logic     in_load;   // latch channel and sample
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     y_load;    // capture rounded output y
    logic     res_load;  // write state back, load output register
  } cmd_t;

  typedef struct packed {
    logic in_enabled;    // channel in range and enabled
    logic out_free;      // output register can take a result
  } status_t;

endpackage

@@ design/mrl_cfg.sv @@
// Configuration registers: filter coefficients and channel enable mask.
// Depends on mrl_pkg.
module mrl_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrl_pkg::COEFF_W-1:0]    cfg_wdata,
  output mrl_pkg::coeff_t                coeff
);

  mrl_pkg::coeff_t coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r.a    <= 16'sd1863;
      coeff_r.b    <= 16'sd11510;
      coeff_r.c    <= 16'sd10360;
      coeff_r.d    <= 16'sd8172;
      coeff_r.mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mrl_pkg::IDX_COEFF_A:     coeff_r.a    <= cfg_wdata;
        mrl_pkg::IDX_COEFF_B:     coeff_r.b    <= cfg_wdata;
        mrl_pkg::IDX_COEFF_C:     coeff_r.c    <= cfg_wdata;
        mrl_pkg::IDX_COEFF_D:     coeff_r.d    <= cfg_wdata;
        mrl_pkg::IDX_ACTIVE_MASK: coeff_r.mask <= cfg_wdata[mrl_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign coeff = coeff_r;

endmodule

@@ design/mrl_ctrl.sv @@
// Sequencer for the shared multiplier: one product per cycle, then write-back.
// Depends on mrl_pkg.
module mrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mrl_pkg::status_t  st,
  output mrl_pkg::cmd_t     cmd
);

  mrl_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrl_pkg::ST_IDLE: begin
        if (in_tvalid && st.in_enabled) state_nxt = mrl_pkg::ST_CX;
      end
      mrl_pkg::ST_CX:   state_nxt = mrl_pkg::ST_DU;
      mrl_pkg::ST_DU:   state_nxt = mrl_pkg::ST_AX;
      mrl_pkg::ST_AX:   state_nxt = mrl_pkg::ST_BU;
      mrl_pkg::ST_BU:   state_nxt = mrl_pkg::ST_CM;
      mrl_pkg::ST_CM:   state_nxt = mrl_pkg::ST_DONE;
      mrl_pkg::ST_DONE: begin
        if (st.out_free) state_nxt = mrl_pkg::ST_IDLE;
      end
      default:          state_nxt = mrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.in_load  = 1'b0;
    cmd.mul_sel  = mrl_pkg::MUL_NONE;
    cmd.acc_op   = mrl_pkg::ACC_HOLD;
    cmd.y_load   = 1'b0;
    cmd.res_load = 1'b0;
    case (state_r)
      mrl_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.in_load = in_tvalid;
      end
      mrl_pkg::ST_CX: cmd.mul_sel = mrl_pkg::MUL_CX;
      mrl_pkg::ST_DU: begin
        cmd.mul_sel = mrl_pkg::MUL_DU;
        cmd.acc_op  = mrl_pkg::ACC_LOAD;
      end
      mrl_pkg::ST_AX: begin
        cmd.mul_sel = mrl_pkg::MUL_AX;
        cmd.acc_op  = mrl_pkg::ACC_ADD_SH;
      end
      mrl_pkg::ST_BU: begin
        cmd.mul_sel = mrl_pkg::MUL_BU;
        cmd.acc_op  = mrl_pkg::ACC_LOAD;
        cmd.y_load  = 1'b1;
      end
      mrl_pkg::ST_CM: begin
        cmd.mul_sel = mrl_pkg::MUL_CM;
        cmd.acc_op  = mrl_pkg::ACC_ADD_SH;
      end
      mrl_pkg::ST_DONE: cmd.res_load = st.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/mrl_dp.sv @@
// Datapath: channel state store, shared 32x17 multiplier, accumulator,
// rounding and saturation, output register. Depends on mrl_pkg.
module mrl_dp #(
  parameter int unsigned NUM_SENSORS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrl_pkg::coeff_t                 coeff,
  input  mrl_pkg::cmd_t                   cmd,
  output mrl_pkg::status_t                st,
  input  logic [mrl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mrl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic signed [mrl_pkg::STATE_W-1:0] state_r [NUM_SENSORS];
  logic [mrl_pkg::CH_W-1:0]           ch_r;
  logic [mrl_pkg::U_W-1:0]            u_r;
  logic signed [mrl_pkg::STATE_W-1:0] y14_r;
  logic signed [mrl_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [mrl_pkg::PROD_W-1:0]  acc_r;
  logic signed [mrl_pkg::OPA_W-1:0]   op_a;
  logic signed [mrl_pkg::OPB_W-1:0]   op_b;
  logic signed [mrl_pkg::STATE_W-1:0] x_cur;
  logic signed [mrl_pkg::OPA_W-1:0]   u_ext;
  logic [mrl_pkg::CH_W-1:0]           in_ch;
  logic [IDX_W-1:0]                   idx;

  // rounding and saturation
  logic signed [mrl_pkg::PROD_W-1:0]  acc_rnd, acc_sh;
  logic signed [mrl_pkg::STATE_W-1:0] q14_sat;
  logic signed [32:0]                 inch_rnd, inch_sh;
  logic signed [mrl_pkg::INCH_W-1:0]  inch_sat;
  logic signed [mrl_pkg::PROD_W-1:0]  cm_rnd, cm_sh;
  logic signed [mrl_pkg::CM_W-1:0]    cm_sat;

  logic                               out_valid_r;
  logic [mrl_pkg::CH_W-1:0]           out_ch_r;
  logic signed [mrl_pkg::INCH_W-1:0]  out_inch_r;
  logic signed [mrl_pkg::CM_W-1:0]    out_cm_r;

  assign in_ch = in_tdata[mrl_pkg::CH_W-1:0];
  assign idx   = ch_r[IDX_W-1:0];
  assign x_cur = state_r[idx];
  assign u_ext = $signed({{(mrl_pkg::OPA_W-mrl_pkg::U_W){1'b0}}, u_r});

  assign st.in_enabled = (32'(in_ch) < NUM_SENSORS) && coeff.mask[in_ch];
  assign st.out_free   = !out_valid_r || out_tready;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ch_r <= in_ch;
      u_r  <= in_tdata[mrl_pkg::CH_W+mrl_pkg::SAMPLE_W-1:mrl_pkg::CH_W+3];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = x_cur;
    op_b = 17'(coeff.c);
    case (cmd.mul_sel)
      mrl_pkg::MUL_CX: begin op_a = x_cur; op_b = 17'(coeff.c); end
      mrl_pkg::MUL_DU: begin op_a = u_ext; op_b = 17'(coeff.d); end
      mrl_pkg::MUL_AX: begin op_a = x_cur; op_b = 17'(coeff.a); end
      mrl_pkg::MUL_BU: begin op_a = u_ext; op_b = 17'(coeff.b); end
      mrl_pkg::MUL_CM: begin op_a = y14_r; op_b = mrl_pkg::CM_PER_INCH_Q14; end
      default: ;
    endcase
    prod_nxt = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != mrl_pkg::MUL_NONE) prod_r <= prod_nxt;
    case (cmd.acc_op)
      mrl_pkg::ACC_LOAD:   acc_r <= prod_r;
      mrl_pkg::ACC_ADD_SH: acc_r <= acc_r + (prod_r <<< 14);
      default: ;
    endcase
    if (cmd.y_load) y14_r <= q14_sat;
  end

  // Q.28 accumulator to Q.14, round half up, saturate to 32 bits
  always_comb begin
    acc_rnd = acc_r + 49'sd8192;
    acc_sh  = acc_rnd >>> 14;
    if (acc_sh > 49'sd2147483647)       q14_sat = 32'sh7FFFFFFF;
    else if (acc_sh < -49'sd2147483648) q14_sat = 32'sh80000000;
    else                                q14_sat = acc_sh[mrl_pkg::STATE_W-1:0];
  end

  // inches: Q.14 to Q.8
  always_comb begin
    inch_rnd = 33'(y14_r) + 33'sd32;
    inch_sh  = inch_rnd >>> 6;
    if (inch_sh > 33'sd262143)       inch_sat = 19'sh3FFFF;
    else if (inch_sh < -33'sd262144) inch_sat = 19'sh40000;
    else                             inch_sat = inch_sh[mrl_pkg::INCH_W-1:0];
  end

  // centimetres: Q.28 product to Q.8
  always_comb begin
    cm_rnd = prod_r + 49'sd524288;
    cm_sh  = cm_rnd >>> 20;
    if (cm_sh > 49'sd1048575)       cm_sat = 21'sh0FFFFF;
    else if (cm_sh < -49'sd1048576) cm_sat = 21'sh100000;
    else                            cm_sat = cm_sh[mrl_pkg::CM_W-1:0];
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SENSORS; k++) state_r[k] <= '0;
    end else if (cmd.res_load) begin
      state_r[idx] <= q14_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_ch_r   <= ch_r;
      out_inch_r <= inch_sat;
      out_cm_r   <= cm_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cm_r, out_inch_r, out_ch_r};

endmodule

@@ design/multichannel_range_lowpass_top.sv @@
// Multichannel range low-pass filter, top level. The single shared 32x17
// multiplier does five products in turn, so a new item is taken only after
// the last one's result is loaded into the output register. A disabled
// channel's item is taken with no result.
// rst_n is synchronous, active low: coefficients return to their defaults,
// the mask and all channel states clear, and the output register empties.
module multichannel_range_lowpass_top #(
  parameter int unsigned NUM_SENSORS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mrl_pkg::IN_DATA_W-1:0]   in_tdata,   // channel[2:0], sample[14:3], pad
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mrl_pkg::OUT_DATA_W-1:0]  out_tdata,  // out_channel[2:0],
                                                      // range_inches[21:3],
                                                      // range_cm[42:22], pad
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrl_pkg::COEFF_W-1:0]     cfg_wdata
);

  mrl_pkg::coeff_t  coeff;
  mrl_pkg::cmd_t    cmd;
  mrl_pkg::status_t st;

  // Coefficients A..D (Q2.14) and the channel enable mask
  mrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coeff     (coeff)
  );

  // Sequencer: IDLE takes a transfer; an enabled item then runs C*x, D*u,
  // A*x, B*u and y*2.54 on the multiplier, one per cycle, and finishes by
  // writing the new state and loading the output register. It waits in the
  // last step while a previous result has not been taken.
  mrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: y = C*x + D*u and x' = A*x + B*u accumulated in Q.28, each
  // rounded half up to Q.14 and saturated; outputs in Q.8, saturated.
  mrl_dp #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .coeff      (coeff),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
